// ===== design/valp_pkg.sv =====
// ----------------------------------------------------------------------------
// valp_pkg
// Shared constants, types and lookup functions for the vertex attribute
// layout packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package valp_pkg;

  localparam int MAX_ATTRS = 16;

  localparam int KIND_W   = 3;
  localparam int COUNT_W  = 3;
  localparam int INDEX_W  = 4;
  localparam int OFFSET_W = 9;
  localparam int SIZE_W   = 5;
  localparam int ALIGN_W  = 3;  // alignment minus one, alignment is 1..8
  localparam int CNT_W    = $clog2(MAX_ATTRS + 1);

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_I8         = 3'd0,
    KIND_U8         = 3'd1,
    KIND_I16        = 3'd2,
    KIND_U16        = 3'd3,
    KIND_I32        = 3'd4,
    KIND_U32        = 3'd5,
    KIND_F32        = 3'd6,
    KIND_PACKED_I10 = 3'd7
  } comp_kind_e;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [ALIGN_W-1:0] align_m;
  } attr_info_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  attr_index;
    logic [OFFSET_W-1:0] attr_offset;
    logic [SIZE_W-1:0]   attr_size;
    logic [OFFSET_W-1:0] stride;
    logic                stride_valid;
    logic                overflow;
  } attr_result_t;

  // log2 of the component size in bytes
  function automatic logic [1:0] comp_bytes_log2(input comp_kind_e kind);
    logic [1:0] res;
    case (kind)
      KIND_I8, KIND_U8:   res = 2'd0;
      KIND_I16, KIND_U16: res = 2'd1;
      default:            res = 2'd2;
    endcase
    return res;
  endfunction

  // round an offset up to a power-of-two alignment, wrapping at 9 bits
  function automatic logic [OFFSET_W-1:0] align_up(input logic [OFFSET_W-1:0] off,
                                                    input logic [ALIGN_W-1:0] align_m);
    logic [OFFSET_W-1:0] sum;
    sum = off + OFFSET_W'(align_m);
    return sum & ~OFFSET_W'(align_m);
  endfunction

endpackage

// ===== design/vertex_attribute_layout_packer_core.sv =====
// ----------------------------------------------------------------------------
// vertex_attribute_layout_packer_core
// Lays out vertex attributes in arrival order and reports the vertex stride.
// ----------------------------------------------------------------------------
// One attribute per clock while the master side keeps tready high: each
// transfer is captured in an input register, placed by a single add-and-mask
// against the running offset, and written to an output register. The first
// attribute of a format (tuser set, or anything after reset or a closed
// format) sits at offset 0; the attribute carrying tlast closes the format
// and returns the stride. Attributes beyond MAX_ATTRS are flagged and ignored.
`timescale 1ns / 1ps

module vertex_attribute_layout_packer_core import valp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // comp_kind[2:0], comp_count[5:3]
  input  logic                 s_axis_tuser,   // first_attr
  input  logic                 s_axis_tlast,   // last_attr
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // attr_index[3:0], attr_offset[12:4],
                                               // attr_size[17:13], stride[26:18]
  output logic                 m_axis_tuser,   // overflow
  output logic                 m_axis_tlast    // stride_valid
);

  logic                in_vld_q;
  logic [KIND_W-1:0]   kind_q;
  logic [COUNT_W-1:0]  count_q;
  logic                first_q;
  logic                last_q;

  logic                out_vld_q;
  attr_result_t        res_q;

  logic                advance;
  attr_info_t          info;
  attr_result_t        res;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q  <= s_axis_tdata[KIND_W-1:0];
      count_q <= s_axis_tdata[KIND_W+COUNT_W-1:KIND_W];
      first_q <= s_axis_tuser;
      last_q  <= s_axis_tlast;
    end
  end

  valp_attr_decode u_decode (
    .comp_kind_i  (kind_q),
    .comp_count_i (count_q),
    .info_o       (info)
  );

  valp_layout u_layout (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .info_i   (info),
    .first_i  (first_q),
    .last_i   (last_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = M_TDATA_W'({res_q.stride, res_q.attr_size,
                                     res_q.attr_offset, res_q.attr_index});
  assign m_axis_tuser  = res_q.overflow;
  assign m_axis_tlast  = res_q.stride_valid;

`ifndef SYNTHESIS
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[12:0] == 13'd0)
    else $error("ignored attribute reported a placement");

  a_stride_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[26:18] == 9'd0)
    else $error("stride reported without closing the format");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17:13] != 5'd0 && m_axis_tdata[17:13] <= 5'd16)
    else $error("attribute size out of range");
`endif

endmodule

// ===== design/valp_attr_decode.sv =====
// ----------------------------------------------------------------------------
// valp_attr_decode
// Byte size and alignment of one attribute from its component type and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module valp_attr_decode import valp_pkg::*; (
  input  logic [KIND_W-1:0]  comp_kind_i,
  input  logic [COUNT_W-1:0] comp_count_i,
  output attr_info_t         info_o
);

  comp_kind_e   kind;
  logic [1:0]   cl;
  logic [2:0]   count;

  assign kind = comp_kind_e'(comp_kind_i);
  assign cl   = comp_bytes_log2(kind);

  always_comb begin
    if (comp_count_i == 3'd0) begin
      count = 3'd1;
    end else if (comp_count_i > 3'd4) begin
      count = 3'd4;
    end else begin
      count = comp_count_i;
    end
  end

  always_comb begin
    if (kind == KIND_PACKED_I10) begin
      info_o.size    = SIZE_W'(4);
      info_o.align_m = ALIGN_W'(3);
    end else begin
      info_o.size = SIZE_W'(count) << cl;
      if (count == 3'd3 && cl != 2'd2) begin
        info_o.align_m = (cl == 2'd1) ? ALIGN_W'(7) : ALIGN_W'(3);
      end else begin
        info_o.align_m = ALIGN_W'((4'd1 << cl) - 4'd1);
      end
    end
  end

endmodule

// ===== design/valp_layout.sv =====
// ----------------------------------------------------------------------------
// valp_layout
// Running offset, first alignment and attribute count of the open format;
// places one attribute per step and computes its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module valp_layout import valp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  attr_info_t   info_i,
  input  logic         first_i,
  input  logic         last_i,
  output attr_result_t result_o
);

  logic [OFFSET_W-1:0] run_off_q, run_off_d;
  logic [ALIGN_W-1:0]  first_align_q, first_align_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic                start;
  logic                ovf;
  logic [OFFSET_W-1:0] place_off;

  assign start     = first_i || (cnt_q == '0);
  assign ovf       = !start && (cnt_q >= CNT_W'(MAX_ATTRS));
  assign place_off = align_up(run_off_q, info_i.align_m);

  always_comb begin
    run_off_d     = run_off_q;
    first_align_d = first_align_q;
    cnt_d         = cnt_q;
    result_o      = '0;
    result_o.attr_size = info_i.size;
    if (start) begin
      run_off_d     = OFFSET_W'(info_i.size);
      first_align_d = info_i.align_m;
      cnt_d         = CNT_W'(1);
    end else if (ovf) begin
      result_o.overflow = 1'b1;
    end else begin
      result_o.attr_index  = INDEX_W'(cnt_q);
      result_o.attr_offset = place_off;
      run_off_d            = place_off + OFFSET_W'(info_i.size);
      cnt_d                = cnt_q + CNT_W'(1);
    end
    if (last_i) begin
      result_o.stride       = align_up(run_off_d, first_align_d);
      result_o.stride_valid = 1'b1;
      cnt_d                 = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_off_q     <= '0;
      first_align_q <= '0;
      cnt_q         <= '0;
    end else if (step_i) begin
      run_off_q     <= run_off_d;
      first_align_q <= first_align_d;
      cnt_q         <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ATTRS))
    else $error("attribute count beyond maximum");

  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> cnt_q == '0)
    else $error("format not closed after last attribute");

  a_ovf_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ovf && !last_i |=> $stable(cnt_q) && $stable(run_off_q))
    else $error("ignored attribute changed layout state");

  a_first_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_align_q == 3'd0 || first_align_q == 3'd1 || first_align_q == 3'd3 ||
    first_align_q == 3'd7)
    else $error("first alignment not a power of two");
`endif

endmodule
